FILE: rtl/sparse_accumulator_spmspv_macros.svh
// assertion macros for the sparse accumulator
`ifndef SPARSE_ACCUMULATOR_SPMSPV_MACROS_SVH
`define SPARSE_ACCUMULATOR_SPMSPV_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spa_pkg.sv
// shared types, constants and fixed-point helpers of the sparse accumulator
package spa_pkg;

    localparam int VERTICES = 1024;
    localparam int VTX_W    = $clog2(VERTICES);
    localparam int CNT_W    = $clog2(VERTICES + 1);
    localparam int VAL_W    = 32;
    localparam int EPOCH_W  = 8;

    // vertex table entry: epoch tag over slot number
    localparam int VTAB_W   = EPOCH_W + VTX_W;
    // slot table entry: vertex over value
    localparam int STAB_W   = VTX_W + VAL_W;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EDGE  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_UNIT  = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_SLOT,
        S_UPD,
        S_RDOUT
    } state_t;

    // q16.16 product: add half an lsb, floor shift, saturate to 32 bits
    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [63:0] prod);
        logic signed [63:0] q;
        logic signed [63:0] r;
        logic signed [VAL_W-1:0] res;
        q = prod + 64'sd32768;
        r = q >>> 16;
        if (r > 64'sd2147483647)
            res = {1'b0, {(VAL_W-1){1'b1}}};
        else if (r < -64'sd2147483648)
            res = {1'b1, {(VAL_W-1){1'b0}}};
        else
            res = r[VAL_W-1:0];
        return res;
    endfunction

    // saturating 32-bit add
    function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        logic signed [VAL_W-1:0] res;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            res = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            res = s[VAL_W-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/spa_ram.sv
// generic single-clock ram, one write and one registered read port
module spa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/spa_qmul.sv
// two-stage q16.16 multiplier: raw product, then rounding and saturation
module spa_qmul
    import spa_pkg::*;
(
    input  logic                    clk,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    output logic signed [VAL_W-1:0] p
);

    logic signed [63:0]      prod_reg;
    logic signed [VAL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
        p_reg    <= round_sat(prod_reg);
    end

    assign p = p_reg;

endmodule

FILE: rtl/sparse_accumulator_spmspv.sv
// top level of the sparse accumulator: command sequencer, tables and register port
//
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------------------
// command   | start, busy                  | command, vertex, sample_value, edge_weight
// result    | done (one-cycle strobe)      | status, entry_vertex, entry_value,
//           |                              | entry_count
// registers | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// sequence: start gives its beat in the cycle after acceptance; read goes via
// S_RDOUT; load and unit-weight edge via S_M1, S_M2, S_SLOT (S_UPD if marked);
// weighted edge adds S_M3, S_M4, as the two-stage multiplier is used twice.
// reset: a sweep tags every vertex as unmarked, busy stays high.
// marks are epoch tags; every 255th start wraps the epoch and repeats the sweep.
// results cannot be stalled; one command is in work at a time.
`include "sparse_accumulator_spmspv_macros.svh"

module sparse_accumulator_spmspv
    import spa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // command side
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [VTX_W-1:0]        vertex,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic signed [VAL_W-1:0] edge_weight,
    // result side
    output logic                    done,
    output logic [1:0]              status,
    output logic [VTX_W-1:0]        entry_vertex,
    output logic signed [VAL_W-1:0] entry_value,
    output logic [CNT_W-1:0]        entry_count,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ---------------- configuration registers ----------------
    logic signed [VAL_W-1:0] alpha_reg;
    logic signed [VAL_W-1:0] beta_reg;
    logic                    unit_reg;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 32'sd65536;
            beta_reg  <= 32'sd65536;
            unit_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ALPHA: alpha_reg <= pwdata;
                REG_BETA:  beta_reg  <= pwdata;
                REG_UNIT:  unit_reg  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ALPHA: prdata = alpha_reg;
            REG_BETA:  prdata = beta_reg;
            REG_UNIT:  prdata = {31'd0, unit_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    state_t                  state_reg, state_next;
    logic [VTX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [EPOCH_W-1:0]      epoch_reg, epoch_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [VTX_W-1:0]        vtx_reg, vtx_next;
    logic signed [VAL_W-1:0] weight_reg, weight_next;
    logic signed [VAL_W-1:0] contrib_reg, contrib_next;
    logic [VTX_W-1:0]        slot_reg, slot_next;

    // result beat registers
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [VTX_W-1:0]        evtx_reg, evtx_next;
    logic signed [VAL_W-1:0] eval_reg, eval_next;
    logic [CNT_W-1:0]        ecount_reg, ecount_next;

    // ---------------- tables ----------------
    logic                    vtab_we, vtab_re;
    logic [VTX_W-1:0]        vtab_waddr;
    logic [VTAB_W-1:0]       vtab_wdata, vtab_rdata;
    logic                    stab_we, stab_re;
    logic [VTX_W-1:0]        stab_waddr, stab_raddr;
    logic [STAB_W-1:0]       stab_wdata, stab_rdata;

    // vertex -> {epoch tag, slot}
    spa_ram #(
        .DATA_W (VTAB_W),
        .DEPTH  (VERTICES)
    ) u_vtab (
        .clk   (clk),
        .we    (vtab_we),
        .waddr (vtab_waddr),
        .wdata (vtab_wdata),
        .re    (vtab_re),
        .raddr (vertex),
        .rdata (vtab_rdata)
    );

    // slot -> {vertex, value}
    spa_ram #(
        .DATA_W (STAB_W),
        .DEPTH  (VERTICES)
    ) u_stab (
        .clk   (clk),
        .we    (stab_we),
        .waddr (stab_waddr),
        .wdata (stab_wdata),
        .re    (stab_re),
        .raddr (stab_raddr),
        .rdata (stab_rdata)
    );

    // ---------------- multiplier ----------------
    logic signed [VAL_W-1:0] mul_a, mul_b, mul_p;

    spa_qmul u_qmul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // ---------------- decode helpers ----------------
    logic                    accept;
    logic [EPOCH_W-1:0]      tab_epoch;
    logic [VTX_W-1:0]        tab_slot;
    logic                    marked;
    logic                    in_range;
    logic                    full;
    logic                    slot_valid;
    logic signed [VAL_W-1:0] slot_sum;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign tab_epoch  = vtab_rdata[VTAB_W-1:VTX_W];
    assign tab_slot   = vtab_rdata[VTX_W-1:0];
    assign marked     = (tab_epoch == epoch_reg);
    assign in_range   = ({{(CNT_W-VTX_W){1'b0}}, vtx_reg} < CNT_W'(VERTICES));
    assign full       = (count_reg >= CNT_W'(VERTICES));
    assign slot_valid = ({{(CNT_W-VTX_W){1'b0}}, vtx_reg} < count_reg);
    assign slot_sum   = sat_add(stab_rdata[VAL_W-1:0], contrib_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        epoch_next   = epoch_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        vtx_next     = vtx_reg;
        weight_next  = weight_reg;
        contrib_next = contrib_reg;
        slot_next    = slot_reg;

        done_next    = 1'b0;
        status_next  = status_reg;
        evtx_next    = evtx_reg;
        eval_next    = eval_reg;
        ecount_next  = ecount_reg;

        vtab_we      = 1'b0;
        vtab_waddr   = vtx_reg;
        vtab_wdata   = {epoch_reg, count_reg[VTX_W-1:0]};
        vtab_re      = accept;
        stab_we      = 1'b0;
        stab_waddr   = count_reg[VTX_W-1:0];
        stab_wdata   = {vtx_reg, contrib_reg};
        stab_re      = 1'b0;
        stab_raddr   = vertex;

        // second product by default: weight times alpha*x
        mul_a        = weight_reg;
        mul_b        = mul_p;

        unique case (state_reg)
            S_CLEAR:
            begin
                // tag every vertex with the never-used epoch zero
                vtab_we    = 1'b1;
                vtab_waddr = clr_idx_reg;
                vtab_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == VTX_W'(VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                mul_a = (cmd_t'(command) == CMD_LOAD) ? beta_reg : alpha_reg;
                mul_b = sample_value;
                if (accept)
                begin
                    cmd_next    = cmd_t'(command);
                    vtx_next    = vertex;
                    weight_next = edge_weight;
                    unique case (cmd_t'(command))
                        CMD_START:
                        begin
                            count_next  = '0;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            evtx_next   = '0;
                            eval_next   = '0;
                            ecount_next = '0;
                            if (epoch_reg == EPOCH_LAST)
                            begin
                                // epoch wraps: sweep old tags away first
                                epoch_next   = EPOCH_FIRST;
                                clr_idx_next = '0;
                                state_next   = S_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                        CMD_LOAD, CMD_EDGE:
                        begin
                            state_next = S_M1;
                        end
                        CMD_READ:
                        begin
                            stab_re    = 1'b1;
                            state_next = S_RDOUT;
                        end
                        default: ;
                    endcase
                end
            end

            S_M1:
            begin
                state_next = S_M2;
            end

            S_M2:
            begin
                // scaled sample ready
                if (cmd_reg == CMD_EDGE && !unit_reg)
                begin
                    state_next = S_M3;
                end
                else
                begin
                    contrib_next = mul_p;
                    state_next   = S_SLOT;
                end
            end

            S_M3:
            begin
                state_next = S_M4;
            end

            S_M4:
            begin
                contrib_next = mul_p;
                state_next   = S_SLOT;
            end

            S_SLOT:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                evtx_next   = vtx_reg;
                eval_next   = '0;
                ecount_next = count_reg;
                priority if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else if (marked)
                begin
                    // existing slot: fetch its value, add next cycle
                    done_next  = 1'b0;
                    stab_re    = 1'b1;
                    stab_raddr = tab_slot;
                    slot_next  = tab_slot;
                    state_next = S_UPD;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // open a new slot at the end of the table
                    vtab_we     = 1'b1;
                    stab_we     = 1'b1;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_OK;
                    eval_next   = contrib_reg;
                    ecount_next = count_reg + 1'b1;
                end
            end

            S_UPD:
            begin
                stab_we     = 1'b1;
                stab_waddr  = slot_reg;
                stab_wdata  = {vtx_reg, slot_sum};
                done_next   = 1'b1;
                status_next = ST_OK;
                evtx_next   = vtx_reg;
                eval_next   = slot_sum;
                ecount_next = count_reg;
                state_next  = S_IDLE;
            end

            S_RDOUT:
            begin
                done_next   = 1'b1;
                ecount_next = count_reg;
                state_next  = S_IDLE;
                if (slot_valid)
                begin
                    status_next = ST_OK;
                    evtx_next   = stab_rdata[STAB_W-1:VAL_W];
                    eval_next   = stab_rdata[VAL_W-1:0];
                end
                else
                begin
                    status_next = ST_RANGE;
                    evtx_next   = '0;
                    eval_next   = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            epoch_reg   <= EPOCH_FIRST;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            epoch_reg   <= epoch_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        vtx_reg     <= vtx_next;
        weight_reg  <= weight_next;
        contrib_reg <= contrib_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        evtx_reg    <= evtx_next;
        eval_reg    <= eval_next;
        ecount_reg  <= ecount_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign entry_vertex = evtx_reg;
    assign entry_value  = eval_reg;
    assign entry_count  = ecount_reg;

    // ---------------- assertions ----------------
    `SPA_ASSERT_NEXT(a_work_holds_busy,
        start && !busy && cmd_t'(command) != CMD_START, busy,
        "accepted load, edge or read did not hold busy")
    `SPA_ASSERT_IMPL(a_full_at_capacity,
        done && status == ST_FULL, entry_count == CNT_W'(VERTICES),
        "table full reported below capacity")
    `SPA_ASSERT_IMPL(a_epoch_nonzero, 1'b1, epoch_reg != '0,
        "epoch collides with the cleared tag")

endmodule

FILE: test/tb.sv
// self-checking testbench for the sparse accumulator: directed and random command streams
module tb
    import spa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // q16.16 landmarks
    localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] Q_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_HALF = 32'sh0000_8000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BEATS = 1450;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              command = CMD_START;
    logic [VTX_W-1:0]        vertex = '0;
    logic signed [VAL_W-1:0] sample_value = '0;
    logic signed [VAL_W-1:0] edge_weight = '0;
    logic                    done;
    logic [1:0]              status;
    logic [VTX_W-1:0]        entry_vertex;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [3:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // one result beat as the block should report it
    typedef struct {
        logic [1:0]              status;
        logic [VTX_W-1:0]        vtx;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        cnt;
    } spa_entry_t;

    // shadow of the accumulator tables plus the queue of results still owed
    class accum_scoreboard;
        bit                      marked [VERTICES];
        logic [VTX_W-1:0]        slot_of [VERTICES];
        logic [VTX_W-1:0]        vtx_of_slot [VERTICES];
        logic signed [VAL_W-1:0] val_of_slot [VERTICES];
        int                      used;
        logic signed [VAL_W-1:0] alpha;
        logic signed [VAL_W-1:0] beta;
        bit                      unit;
        spa_entry_t              expected_entries [$];
        int                      failures;

        function new();
            foreach (marked[i]) marked[i] = 1'b0;
            used = 0;
            alpha = Q_ONE;
            beta = Q_ONE;
            unit = 1'b0;
            failures = 0;
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        function int occupied();
            return used;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_ALPHA: alpha = d;
                REG_BETA:  beta = d;
                REG_UNIT:  unit = d[0];
                default:   ;
            endcase
        endfunction

        function logic signed [VAL_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return Q_MAX;
            if (v < -64'sd2147483648)
                return Q_MIN;
            return v[VAL_W-1:0];
        endfunction

        // exact product, half lsb added, floor by 2^16
        function logic signed [VAL_W-1:0] fx_mul(logic signed [VAL_W-1:0] a,
                                                 logic signed [VAL_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b) + 64'sd32768;
            return clamp32(p >>> 16);
        endfunction

        function spa_entry_t add_to_vertex(logic [VTX_W-1:0] v, logic signed [VAL_W-1:0] c);
            spa_entry_t r;
            int k;
            r.status = ST_OK;
            r.vtx = v;
            r.val = '0;
            if (int'(v) >= VERTICES) begin
                r.status = ST_RANGE;
            end
            else if (marked[v]) begin
                k = int'(slot_of[v]);
                val_of_slot[k] = clamp32(longint'(val_of_slot[k]) + longint'(c));
                r.val = val_of_slot[k];
            end
            else if (used >= VERTICES) begin
                r.status = ST_FULL;
            end
            else begin
                k = used;
                used++;
                marked[v] = 1'b1;
                slot_of[v] = k[VTX_W-1:0];
                vtx_of_slot[k] = v;
                val_of_slot[k] = c;
                r.val = c;
            end
            r.cnt = used[CNT_W-1:0];
            return r;
        endfunction

        function void note_command(cmd_t cmd, logic [VTX_W-1:0] v,
                                   logic signed [VAL_W-1:0] s, logic signed [VAL_W-1:0] w);
            spa_entry_t r;
            logic signed [VAL_W-1:0] ax;
            case (cmd)
                CMD_START: begin
                    foreach (marked[i]) marked[i] = 1'b0;
                    used = 0;
                    r.status = ST_OK;
                    r.vtx = '0;
                    r.val = '0;
                    r.cnt = '0;
                end
                CMD_LOAD: r = add_to_vertex(v, fx_mul(beta, s));
                CMD_EDGE: begin
                    ax = fx_mul(alpha, s);
                    r = add_to_vertex(v, unit ? ax : fx_mul(w, ax));
                end
                default: begin
                    r.cnt = used[CNT_W-1:0];
                    if (int'(v) >= used) begin
                        r.status = ST_RANGE;
                        r.vtx = '0;
                        r.val = '0;
                    end
                    else begin
                        r.status = ST_OK;
                        r.vtx = vtx_of_slot[v];
                        r.val = val_of_slot[v];
                    end
                end
            endcase
            expected_entries.push_back(r);
        endfunction

        function void check_entry(logic [1:0] st, logic [VTX_W-1:0] vx,
                                  logic signed [VAL_W-1:0] vl, logic [CNT_W-1:0] ct);
            spa_entry_t e;
            if (expected_entries.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: status %0d vertex %0d value %0d count %0d",
                             st, vx, vl, ct);
                return;
            end
            e = expected_entries.pop_front();
            if (st !== e.status || vx !== e.vtx || vl !== e.val || ct !== e.cnt) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: status %0d/%0d vertex %0d/%0d value %0d/%0d count %0d/%0d",
                             e.status, st, e.vtx, vx, e.val, vl, e.cnt, ct);
            end
        endfunction
    endclass

    accum_scoreboard board;
    int  beats_sent = 0;
    int  cycles = 0;
    int  phase;
    bit  no_idle = 1'b0;

    sparse_accumulator_spmspv uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .vertex       (vertex),
        .sample_value (sample_value),
        .edge_weight  (edge_weight),
        .done         (done),
        .status       (status),
        .entry_vertex (entry_vertex),
        .entry_value  (entry_value),
        .entry_count  (entry_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // watchdog over the whole run, covers the clearing sweeps too
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // results cannot be held off, so every strobe is a beat to check
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_entry(status, entry_vertex, entry_value, entry_count);
    end

    // mostly back to back, sometimes a pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // q16.16 operand: landmarks, rounding ties, small values and full range
    function automatic logic signed [VAL_W-1:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return r[0] ? Q_HALF : -Q_HALF;
            6, 7: return r;
            default: return {{14{r[31]}}, r[17:0]};
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_scale();
        if ($urandom_range(3) == 0)
            return Q_ONE;
        return rand_value();
    endfunction

    function automatic logic [VTX_W-1:0] pick_vertex();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return VTX_W'($urandom_range(VERTICES - 1));
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(2, 12);
        return $urandom_range(20, 80);
    endfunction

    // one command beat; start stays high when the next beat follows at once
    task automatic send_beat(cmd_t cmd, logic [VTX_W-1:0] v,
                             logic signed [VAL_W-1:0] s, logic signed [VAL_W-1:0] w);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        vertex <= v;
        sample_value <= s;
        edge_weight <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_command(cmd, v, s, w);
        beats_sent++;
    endtask

    // hold the sender until every owed result is back and the block is free
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0 || busy !== 1'b0);
    endtask

    // setup cycle then access cycle, register lands when pready is seen
    task automatic write_register(reg_idx_t idx, logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_register(idx, d);
    endtask

    task automatic configure(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b, bit u);
        write_register(REG_ALPHA, a);
        write_register(REG_BETA, b);
        write_register(REG_UNIT, {31'b0, u});
    endtask

    // one product: start, then loads and edges over a small vertex pool, slot reads and noise
    task automatic run_product(int len);
        logic [VTX_W-1:0] pool [16];
        int pool_n;
        int pick;
        int cnt;
        logic [VTX_W-1:0] slot;
        pool_n = $urandom_range(1, 16);
        for (int i = 0; i < pool_n; i++)
            pool[i] = pick_vertex();
        send_beat(CMD_START, pick_vertex(), rand_value(), rand_value());
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            cnt = board.occupied();
            // occasional drain mid-stream puts pressure on the idle path
            if (pick < 3)
                wait_drained();
            if (pick < 30)
                send_beat(CMD_LOAD, pool[$urandom_range(pool_n - 1)], rand_value(), rand_value());
            else if (pick < 65)
                send_beat(CMD_EDGE, pool[$urandom_range(pool_n - 1)], rand_value(), rand_value());
            else if (pick < 85)
            begin
                slot = (cnt > 0) ? VTX_W'($urandom_range(cnt - 1)) : '0;
                send_beat(CMD_READ, slot, rand_value(), rand_value());
            end
            else if (pick < 90)
            begin
                slot = (cnt < VERTICES) ? VTX_W'($urandom_range(VERTICES - 1, cnt))
                                        : VTX_W'($urandom_range(VERTICES - 1));
                send_beat(CMD_READ, slot, rand_value(), rand_value());
            end
            else
                // noise: any command with any fields
                send_beat(cmd_t'($urandom_range(3)), VTX_W'($urandom_range(VERTICES - 1)),
                          $urandom, $urandom);
        end
    endtask

    // many starts in a row walk the mark epochs toward their wrap
    task automatic start_storm();
        for (int i = 0; i < 300; i++)
        begin
            case ($urandom_range(7))
                0: send_beat(CMD_LOAD, VTX_W'($urandom_range(7)), rand_value(), rand_value());
                1: send_beat(CMD_EDGE, VTX_W'($urandom_range(7)), rand_value(), rand_value());
                default: send_beat(CMD_START, pick_vertex(), rand_value(), rand_value());
            endcase
            if ($urandom_range(15) == 0)
                send_beat(CMD_READ, VTX_W'($urandom_range(3)), rand_value(), rand_value());
        end
    endtask

    // every vertex once in shuffled order, so the count reaches its top
    task automatic fill_table();
        logic [VTX_W-1:0] order [VERTICES];
        logic [VTX_W-1:0] t;
        int j;
        for (int i = 0; i < VERTICES; i++)
            order[i] = VTX_W'(i);
        for (int i = VERTICES - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        send_beat(CMD_START, pick_vertex(), rand_value(), rand_value());
        for (int i = 0; i < VERTICES; i++)
            send_beat((i % 2) ? CMD_EDGE : CMD_LOAD, order[i], rand_value(), rand_value());
        // full table: only existing slots can be hit now
        repeat (6)
            send_beat(($urandom_range(1) != 0) ? CMD_EDGE : CMD_LOAD, pick_vertex(),
                      rand_value(), rand_value());
        send_beat(CMD_READ, VTX_W'(VERTICES - 1), rand_value(), rand_value());
        send_beat(CMD_READ, '0, rand_value(), rand_value());
        send_beat(CMD_READ, VTX_W'($urandom_range(VERTICES - 1)), rand_value(), rand_value());
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset scales: empty read, saturating sums, rounding ties
        send_beat(CMD_START, '0, '0, '0);
        send_beat(CMD_READ, '0, '0, '0);
        send_beat(CMD_LOAD, '0, Q_MAX, Q_MIN);
        send_beat(CMD_LOAD, '1, Q_MIN, Q_MAX);
        send_beat(CMD_LOAD, '0, Q_MAX, '0);
        send_beat(CMD_EDGE, '1, Q_MIN, Q_MIN);
        send_beat(CMD_EDGE, 10'd512, Q_HALF, 32'sd1);
        send_beat(CMD_EDGE, 10'd513, -Q_HALF, -Q_ONE);
        send_beat(CMD_READ, 10'd0, '0, '0);
        send_beat(CMD_READ, 10'd1, '0, '0);
        send_beat(CMD_READ, 10'd2, '0, '0);
        send_beat(CMD_READ, 10'd4, '0, '0);
        send_beat(CMD_READ, '1, '0, '0);
        // restart: marks gone, old slots unreachable
        send_beat(CMD_START, '1, Q_MAX, Q_MAX);
        send_beat(CMD_READ, '0, '0, '0);
        send_beat(CMD_LOAD, '0, Q_ONE, '0);

        // extreme scales, weights ignored in unit mode
        wait_drained();
        configure(Q_MAX, Q_MIN, 1'b1);
        send_beat(CMD_LOAD, 10'd7, Q_MAX, '0);
        send_beat(CMD_EDGE, 10'd7, Q_MIN, 32'sh1234_5678);
        send_beat(CMD_EDGE, 10'd8, 32'sd1, '0);
        send_beat(CMD_READ, 10'd1, '0, '0);

        wait_drained();
        configure(Q_MIN, '0, 1'b0);
        send_beat(CMD_EDGE, 10'd9, Q_MIN, Q_MIN);
        send_beat(CMD_EDGE, 10'd9, Q_MAX, -Q_ONE);
        send_beat(CMD_LOAD, 10'd9, 32'sd123, '0);
        send_beat(CMD_READ, 10'd2, '0, '0);

        // random phases, each under fresh scales written while idle
        phase = 0;
        while (beats_sent < RANDOM_BEATS || phase < 6)
        begin
            wait_drained();
            configure(pick_scale(), pick_scale(), 1'($urandom_range(1)));
            no_idle = ($urandom_range(3) == 0);
            if (phase == 2)
                start_storm();
            else if (phase == 4)
                fill_table();
            else
                repeat ($urandom_range(1, 4)) run_product(pick_len());
            phase++;
        end

        wait_drained();
        // settle time for any stray beat
        repeat (20) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
